### design/ghm_pkg.sv
package ghm_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DIMQ_W = $clog2(MAX_DIM) + 1;
  localparam int GRID_STEPS = DIMQ_W;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CSW_W = ADDR_W + 1;

  localparam int CNT_W = 16;
  localparam int NB_W = 4;
  localparam int SUM_W = CNT_W + 3;
  localparam int PROD_W = CNT_W + NB_W;
  localparam int VAL_W = 17;
  localparam logic [VAL_W-1:0] FULL_SCALE = VAL_W'(65536);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int DIVD_W = 40;
  localparam int DIVS_W = 32;
  localparam int QUOT_W = 17;
  localparam int NORM_STEPS = 17;
  localparam int STEP_W = 5;
  localparam int DSH_W = DIVS_W + NORM_STEPS;

  typedef enum logic [2:0] {
    REG_MIN_X, REG_MIN_Y, REG_MAX_X, REG_MAX_Y, REG_CELL_SIZE, REG_MODE, REG_MAX_REF
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FUNC_CLEAR, FUNC_ADD, FUNC_READ, FUNC_NONE
  } func_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_GCOL, S_GROW, S_PX, S_PY, S_ADD_RD, S_ADD_WR,
    S_NB, S_NORM, S_OUT
  } state_e;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  function automatic logic signed [1:0] nb_dx(input logic [NB_W-1:0] k);
    logic signed [1:0] r;
    case (k)
      4'd1, 4'd4, 4'd6: r = -2'sd1;
      4'd3, 4'd5, 4'd8: r = 2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [NB_W-1:0] k);
    logic signed [1:0] r;
    case (k)
      4'd1, 4'd2, 4'd3: r = -2'sd1;
      4'd6, 4'd7, 4'd8: r = 2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [8:0] y, input logic [8:0] x);
    logic [31:0] t;
    t = 32'(y) * 32'(MAX_COLS) + 32'(x);
    return t[ADDR_W-1:0];
  endfunction

endpackage

### design/grid_density_heatmap_core.sv
// A read passes through two grid divisions, a neighbor scan of the count memory and a
// normalization division in either mode, skipping the normalization for a cell outside the
// grid or a zero reference. An add passes through four divisions and a read and write of its
// count, or stops early for a dropped point; a clear writes all 4096 entries, one entry a cycle.
// One transaction is worked on at a time; the next is taken once the core is idle again, even
// while a result waits. After reset the count memory is cleared; configuration is always taken.
module grid_density_heatmap_core
  import ghm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [5:0]         cell_x_i,
  input  logic [5:0]         cell_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [16:0]        cell_value_o,
  output logic               cell_ok_o
);

  logic signed [31:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic [30:0]        cell_size_q;
  logic               mode_q;
  logic [15:0]        max_ref_q;

  state_e state_q, state_d;
  logic   started_q, started_d;
  logic [CSW_W-1:0] sweep_q;
  logic [NB_W-1:0]  k_q;
  logic             out_valid_q;

  func_e              func_q;
  logic signed [31:0] px_q, py_q;
  logic [5:0]         cx_q, cy_q;
  logic [DIMQ_W-1:0]  cols_q, rows_q, gx_q, gy_q;
  logic [CNT_W-1:0]   count_q, rdata_q;
  logic [SUM_W-1:0]   sum_q;
  logic [NB_W-1:0]    n_q;
  logic               rv_q, rc_q;
  logic [VAL_W-1:0]   val_q;
  logic               ok_q;

  logic [CNT_W-1:0] mem [DEPTH];

  logic              div_start, div_norm;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  div_res_t          div_res;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CNT_W-1:0]  wdata;

  logic [30:0]        cs_eff;
  logic signed [32:0] wx, wy;
  logic [33:0]        cnum_x, cnum_y;
  logic [DIMQ_W-1:0]  dim_res;
  logic               px_out, py_out, pos_drop, rd_ok;
  logic signed [8:0]  nx, ny;
  logic               nb_ok;
  logic [PROD_W-1:0]  cn, num, den;
  logic [VAL_W-1:0]   norm_val;

  ghm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .norm_i    (div_norm),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .res_o     (div_res)
  );

  always_comb begin
    cs_eff = (cell_size_q == '0) ? 31'd1 : cell_size_q;
    wx = {max_x_q[31], max_x_q} - {min_x_q[31], min_x_q};
    wy = {max_y_q[31], max_y_q} - {min_y_q[31], min_y_q};
    cnum_x = (wx[32] ? 34'd0 : 34'(wx[31:0])) + 34'(cs_eff) - 34'd1;
    cnum_y = (wy[32] ? 34'd0 : 34'(wy[31:0])) + 34'(cs_eff) - 34'd1;
    if (div_res.sat || div_res.quot[DIMQ_W-1:0] > DIMQ_W'(MAX_DIM)) begin
      dim_res = DIMQ_W'(MAX_DIM);
    end else if (div_res.quot[DIMQ_W-1:0] == '0) begin
      dim_res = DIMQ_W'(1);
    end else begin
      dim_res = div_res.quot[DIMQ_W-1:0];
    end
    px_out = px_q < min_x_q || px_q >= max_x_q;
    py_out = py_q < min_y_q || py_q >= max_y_q;
    rd_ok = DIMQ_W'(cx_q) < cols_q && DIMQ_W'(cy_q) < rows_q;
    nx = 9'(signed'({3'b000, cx_q})) + 9'(nb_dx(k_q));
    ny = 9'(signed'({3'b000, cy_q})) + 9'(nb_dy(k_q));
    nb_ok = k_q <= NB_W'(8) && !nx[8] && !ny[8] && nx < 9'(signed'({2'b00, cols_q}))
            && ny < 9'(signed'({2'b00, rows_q})) && (k_q == '0 || mode_q);
    cn = PROD_W'(count_q) * PROD_W'(n_q);
    if (n_q == '0) begin
      num = PROD_W'(count_q);
      den = PROD_W'(max_ref_q);
    end else begin
      num = (cn >= PROD_W'(sum_q)) ? cn - PROD_W'(sum_q) : PROD_W'(sum_q) - cn;
      den = PROD_W'(max_ref_q) * PROD_W'(n_q);
    end
    norm_val = (div_res.sat || div_res.quot > FULL_SCALE) ? FULL_SCALE : div_res.quot;
    pos_drop = div_res.sat || div_res.quot[DIMQ_W-1:0] >= (state_q == S_PX ? cols_q : rows_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (sweep_q == CSW_W'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (func_e'(func_i))
            FUNC_CLEAR: state_d = S_CLEAR;
            FUNC_ADD, FUNC_READ: state_d = S_GCOL;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (sweep_q == CSW_W'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_GCOL: begin
        if (started_q && div_res.done) state_d = S_GROW;
      end
      S_GROW: begin
        if (started_q && div_res.done) state_d = (func_q == FUNC_ADD) ? S_PX : S_NB;
      end
      S_PX: begin
        if (!started_q && px_out) state_d = S_IDLE;
        else if (started_q && div_res.done) state_d = pos_drop ? S_IDLE : S_PY;
      end
      S_PY: begin
        if (!started_q && py_out) state_d = S_IDLE;
        else if (started_q && div_res.done) state_d = pos_drop ? S_IDLE : S_ADD_RD;
      end
      S_ADD_RD: state_d = S_ADD_WR;
      S_ADD_WR: state_d = S_IDLE;
      S_NB: begin
        if (!rd_ok || max_ref_q == '0) state_d = S_OUT;
        else if (k_q == NB_W'(9)) state_d = S_NORM;
      end
      S_NORM: begin
        if (started_q && div_res.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_norm = 1'b0;
    div_dividend = '0;
    div_divisor = DIVS_W'(cs_eff);
    we = 1'b0;
    waddr = sweep_q[ADDR_W-1:0];
    wdata = '0;
    raddr = addr_of(9'(ny), 9'(nx));
    case (state_q)
      S_INIT, S_CLEAR: we = 1'b1;
      S_GCOL: begin
        div_start = !started_q;
        div_dividend = DIVD_W'(cnum_x);
      end
      S_GROW: begin
        div_start = !started_q;
        div_dividend = DIVD_W'(cnum_y);
      end
      S_PX: begin
        div_start = !started_q && !px_out;
        div_dividend = DIVD_W'($unsigned(px_q - min_x_q));
      end
      S_PY: begin
        div_start = !started_q && !py_out;
        div_dividend = DIVD_W'($unsigned(py_q - min_y_q));
      end
      S_ADD_RD: raddr = addr_of(9'(gy_q), 9'(gx_q));
      S_ADD_WR: begin
        we = 1'b1;
        waddr = addr_of(9'(gy_q), 9'(gx_q));
        wdata = (rdata_q == CNT_MAX) ? CNT_MAX : rdata_q + CNT_W'(1);
      end
      S_NORM: begin
        div_start = !started_q;
        div_norm = 1'b1;
        div_dividend = DIVD_W'({num, 16'h0000});
        div_divisor = DIVS_W'(den);
      end
      default: ;
    endcase
    started_d = div_start ? 1'b1 : (div_res.done ? 1'b0 : started_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      started_q <= 1'b0;
      sweep_q <= '0;
      k_q <= '0;
      out_valid_q <= 1'b0;
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= 32'sd16384;
      max_y_q <= 32'sd16384;
      cell_size_q <= 31'd256;
      mode_q <= 1'b0;
      max_ref_q <= 16'd10;
    end else begin
      state_q <= state_d;
      started_q <= started_d;
      if (state_q == S_INIT || state_q == S_CLEAR) sweep_q <= sweep_q + CSW_W'(1);
      else sweep_q <= '0;
      if (state_q == S_NB) k_q <= k_q + NB_W'(1);
      else k_q <= '0;
      if (state_q == S_OUT && state_d == S_IDLE) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MIN_X:     min_x_q <= cfg_data_i;
          REG_MIN_Y:     min_y_q <= cfg_data_i;
          REG_MAX_X:     max_x_q <= cfg_data_i;
          REG_MAX_Y:     max_y_q <= cfg_data_i;
          REG_CELL_SIZE: cell_size_q <= cfg_data_i[30:0];
          REG_MODE:      mode_q <= cfg_data_i[0];
          REG_MAX_REF:   max_ref_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      func_q <= func_e'(func_i);
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      cx_q <= cell_x_i;
      cy_q <= cell_y_i;
      val_q <= '0;
    end
    if (state_q == S_GCOL && div_res.done) cols_q <= dim_res;
    if (state_q == S_GROW && div_res.done) begin
      rows_q <= dim_res;
      sum_q <= '0;
      n_q <= '0;
      rv_q <= 1'b0;
    end
    if (state_q == S_PX && div_res.done) gx_q <= div_res.quot[DIMQ_W-1:0];
    if (state_q == S_PY && div_res.done) gy_q <= div_res.quot[DIMQ_W-1:0];
    if (state_q == S_NB) begin
      ok_q <= rd_ok;
      rv_q <= nb_ok;
      rc_q <= k_q == '0;
      if (rv_q) begin
        if (rc_q) begin
          count_q <= rdata_q;
        end else begin
          sum_q <= sum_q + SUM_W'(rdata_q);
          n_q <= n_q + NB_W'(1);
        end
      end
    end
    if (state_q == S_NORM && div_res.done) val_q <= norm_val;
    if (state_q == S_OUT && state_d == S_IDLE) begin
      cell_value_o <= val_q;
      cell_ok_o <= ok_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_INIT || state_q == S_CLEAR || state_q == S_ADD_WR))
    else $error("count memory written outside clear or add");

  a_out_from_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised without a finished read");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cell_value_o <= FULL_SCALE)
    else $error("heat value above full scale");

  a_bad_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cell_ok_o) |-> cell_value_o == '0)
    else $error("cell outside the grid gave nonzero heat");

endmodule

### design/ghm_div.sv
module ghm_div
  import ghm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              norm_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output div_res_t          res_o
);

  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [DSH_W-1:0]  dsh_q, dsh_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              sat_q, sat_d;
  logic [DSH_W-1:0]  full;
  logic              ge;

  always_comb begin
    full = norm_i ? (DSH_W'(divisor_i) << NORM_STEPS) : (DSH_W'(divisor_i) << GRID_STEPS);
    ge = DSH_W'(rem_q) >= dsh_q;
    rem_d = rem_q;
    dsh_d = dsh_q;
    quot_d = quot_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    sat_d = sat_q;
    if (start_i) begin
      rem_d = dividend_i;
      dsh_d = full >> 1;
      quot_d = '0;
      sat_d = DSH_W'(dividend_i) >= full;
      cnt_d = sat_d ? '0 : (norm_i ? STEP_W'(NORM_STEPS) : STEP_W'(GRID_STEPS));
      busy_d = 1'b1;
    end else if (busy_q && cnt_q != '0) begin
      if (ge) begin
        rem_d = rem_q - dsh_q[DIVD_W-1:0];
      end
      quot_d = {quot_q[QUOT_W-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - STEP_W'(1);
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quot_q <= quot_d;
    sat_q <= sat_d;
  end

  assign res_o.done = busy_q && cnt_q == '0;
  assign res_o.sat = sat_q;
  assign res_o.quot = quot_q;

endmodule

### bench/heatmap_checker.sv
`timescale 1ns / 100ps

module heatmap_checker
  import ghm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [5:0]         cell_x_i,
  input  logic [5:0]         cell_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [16:0]        cell_value_i,
  input  logic               cell_ok_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [16:0] value;
    logic        ok;
  } heat_t;

  logic [31:0] lo_x, lo_y, hi_x, hi_y;
  logic [30:0] cell_len;
  logic        contrast;
  logic [15:0] full_ref;
  logic [15:0] counts[DEPTH];
  heat_t       heat_q[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = heat_q.size();

  function automatic longint side_len();
    return (cell_len == 0) ? 64'd1 : longint'(cell_len);
  endfunction

  function automatic longint grid_span(logic [31:0] lo, logic [31:0] hi, int cap);
    longint w;
    longint n;
    w = longint'($signed(hi)) - longint'($signed(lo));
    if (w < 0) w = 0;
    n = (w + side_len() - 1) / side_len();
    if (n < 1) n = 1;
    if (n > cap) n = cap;
    return n;
  endfunction

  function automatic longint bin_of(logic [31:0] pos, logic [31:0] lo, logic [31:0] hi,
                                    longint n);
    longint p;
    longint l;
    longint c;
    p = longint'($signed(pos));
    l = longint'($signed(lo));
    if (p < l || p >= longint'($signed(hi))) return -1;
    c = (p - l) / side_len();
    if (c >= n) return -1;
    return c;
  endfunction

  function automatic logic [16:0] ratio_q16(longint num, longint den);
    longint v;
    v = (num * 65536) / den;
    return (v > 65536) ? 17'd65536 : 17'(v);
  endfunction

  function automatic heat_t heat_at(int x, int y, longint cols, longint rows);
    heat_t  r;
    longint cnt;
    longint sum;
    longint n;
    longint diff;
    int     nx;
    int     ny;
    r.value = '0;
    r.ok    = (x < cols && y < rows);
    if (r.ok && full_ref != 0) begin
      cnt = counts[y * MAX_COLS + x];
      sum = 0;
      n   = 0;
      if (contrast) begin
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            nx = x + dx;
            ny = y + dy;
            if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < cols && ny < rows) begin
              sum += counts[ny * MAX_COLS + nx];
              n++;
            end
          end
        end
      end
      if (n == 0) begin
        r.value = ratio_q16(cnt, full_ref);
      end else begin
        diff = cnt * n - sum;
        if (diff < 0) diff = -diff;
        r.value = ratio_q16(diff, n * full_ref);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint cols;
    longint rows;
    longint bx;
    longint by;
    heat_t  want;
    if (!rst_ni) begin
      lo_x     = 0;
      lo_y     = 0;
      hi_x     = 16384;
      hi_y     = 16384;
      cell_len = 256;
      contrast = 1'b0;
      full_ref = 10;
      foreach (counts[i]) counts[i] = '0;
      heat_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (heat_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result value=%0d ok=%0d", cell_value_i,
                                     cell_ok_i);
        end else begin
          want = heat_q.pop_front();
          if (cell_value_i !== want.value || cell_ok_i !== want.ok) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected value=%0d ok=%0d, got value=%0d ok=%0d",
                       want.value, want.ok, cell_value_i, cell_ok_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MIN_X:     lo_x = cfg_data_i;
          REG_MIN_Y:     lo_y = cfg_data_i;
          REG_MAX_X:     hi_x = cfg_data_i;
          REG_MAX_Y:     hi_y = cfg_data_i;
          REG_CELL_SIZE: cell_len = cfg_data_i[30:0];
          REG_MODE:      contrast = cfg_data_i[0];
          REG_MAX_REF:   full_ref = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        cols = grid_span(lo_x, hi_x, MAX_COLS);
        rows = grid_span(lo_y, hi_y, MAX_ROWS);
        case (func_e'(func_i))
          FUNC_CLEAR: foreach (counts[i]) counts[i] = '0;
          FUNC_ADD: begin
            bx = bin_of(pos_x_i, lo_x, hi_x, cols);
            by = bin_of(pos_y_i, lo_y, hi_y, rows);
            if (bx >= 0 && by >= 0 && counts[by * MAX_COLS + bx] != CNT_MAX)
              counts[by * MAX_COLS + bx]++;
          end
          FUNC_READ: heat_q.push_back(heat_at(cell_x_i, cell_y_i, cols, rows));
          default: ;
        endcase
      end
    end
  end

  initial errors = 0;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ghm_pkg::*;

  localparam longint LIMIT = 3000000;
  localparam int SETTLE = 4200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic [5:0]         cell_x_i = '0;
  logic [5:0]         cell_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [16:0]        cell_value_o;
  logic               cell_ok_o;
  int                 errors;
  int                 pending;
  longint             cycles = 0;
  bit                 calm = 1'b0;
  int                 hold = 0;
  logic [31:0]        cur_lo_x, cur_lo_y, cur_hi_x, cur_hi_y;

  grid_density_heatmap_core dut (.*);

  heatmap_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .pos_x_i, .pos_y_i, .cell_x_i,
    .cell_y_i, .out_valid_i(out_valid_o), .out_ready_i, .cell_value_i(cell_value_o),
    .cell_ok_i(cell_ok_o), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold > 0) begin
      hold <= hold - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 49) == 0) begin
      hold <= $urandom_range(10, 60);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 3) != 0);
    end
  end

  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [31:0] pick_pos(logic [31:0] lo, logic [31:0] hi);
    longint w;
    w = longint'($signed(hi)) - longint'($signed(lo));
    if (w <= 0 || $urandom_range(0, 4) == 0) return $urandom;
    return 32'(longint'($signed(lo)) + ({$urandom, $urandom} % w));
  endfunction

  task automatic set_reg(cfg_reg_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MIN_X: cur_lo_x = d;
      REG_MIN_Y: cur_lo_y = d;
      REG_MAX_X: cur_hi_x = d;
      REG_MAX_Y: cur_hi_y = d;
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] lx, logic [31:0] ly, logic [31:0] hx, logic [31:0] hy,
                       logic [31:0] cs, logic [31:0] md, logic [31:0] rf);
    set_reg(REG_MIN_X, lx);
    set_reg(REG_MIN_Y, ly);
    set_reg(REG_MAX_X, hx);
    set_reg(REG_MAX_Y, hy);
    set_reg(REG_CELL_SIZE, cs);
    set_reg(REG_MODE, md);
    set_reg(REG_MAX_REF, rf);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send(func_e f, logic [31:0] px, logic [31:0] py, logic [5:0] cx,
                      logic [5:0] cy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    pos_x_i    <= px;
    pos_y_i    <= py;
    cell_x_i   <= cx;
    cell_y_i   <= cy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_run(int n);
    int   r;
    func_e f;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 199);
      if (r < 2) f = FUNC_CLEAR;
      else if (r < 6) f = FUNC_NONE;
      else if (r < 120) f = FUNC_ADD;
      else f = FUNC_READ;
      send(f, pick_pos(cur_lo_x, cur_hi_x), pick_pos(cur_lo_y, cur_hi_y),
           ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
           ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)));
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    cur_lo_x = 0;
    cur_lo_y = 0;
    cur_hi_x = 16384;
    cur_hi_y = 16384;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(FUNC_READ, 0, 0, 0, 0);
    send(FUNC_ADD, 0, 0, 0, 0);
    send(FUNC_ADD, 255, 255, 0, 0);
    send(FUNC_ADD, 16383, 16383, 0, 0);
    send(FUNC_ADD, 16384, 0, 0, 0);
    send(FUNC_ADD, 0, 16384, 0, 0);
    send(FUNC_ADD, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
    send(FUNC_ADD, 32'hffff_ffff, 300, 0, 0);
    send(FUNC_ADD, 256, 0, 0, 0);
    send(FUNC_READ, 0, 0, 0, 0);
    send(FUNC_READ, 0, 0, 63, 63);
    send(FUNC_READ, 0, 0, 1, 0);
    send(FUNC_NONE, 0, 0, 0, 0);
    send(FUNC_CLEAR, 0, 0, 0, 0);
    send(FUNC_READ, 0, 0, 0, 0);
    drain();
    setup(0, 0, 768, 768, 256, 1, 1);
    send(FUNC_ADD, 256, 256, 0, 0);
    send(FUNC_ADD, 256, 256, 0, 0);
    send(FUNC_ADD, 0, 0, 0, 0);
    send(FUNC_READ, 0, 0, 1, 1);
    send(FUNC_READ, 0, 0, 0, 0);
    send(FUNC_READ, 0, 0, 2, 2);
    send(FUNC_READ, 0, 0, 3, 0);
    drain();

    setup(0, 0, 16384, 16384, 256, 0, 10);
    random_run(170);
    setup(-1024, -512, 1024, 512, 200, 1, 4);
    random_run(170);
    setup(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1,
          65535);
    random_run(150);
    setup(0, 10, 5, 10, 0, 1, 1);
    random_run(170);
    setup(100, 0, -100, 3000, 1000, 0, 0);
    random_run(150);
    setup(0, 0, 32'h7fff_ffff, 40, 1, 1, 2);
    random_run(170);

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/ghm_pkg.sv
design/ghm_div.sv
design/grid_density_heatmap_core.sv
bench/heatmap_checker.sv
bench/testbench.sv
